// ===== src/line_sensor_scan_centroid_unit_defines.svh =====
// Assertion helpers for the line sensor scan unit.
// Both expect signals named clock and reset in the enclosing scope.
`ifndef LINE_SENSOR_SCAN_CENTROID_UNIT_DEFINES_SVH
`define LINE_SENSOR_SCAN_CENTROID_UNIT_DEFINES_SVH

// Same-cycle implication
`define LSSC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define LSSC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lssc_pkg.sv =====
`default_nettype none

package lssc_pkg;

   // Fixed field widths
   localparam int MUX_W    = 3;
   localparam int MAP_W    = 8;
   localparam int POS_W    = 11;
   localparam int SETTLE_W = 16;

   localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd160;
   localparam int NUM_CHANNELS_DEF = 8;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN
   } lssc_state_type;

   // Controller to datapath
   typedef struct packed {
      logic step;        // input word accepted
      logic div_start;   // this word ends a scan with hits: load divider
      logic div_run;     // one quotient bit
      logic div_finish;  // sign fix, write position and result
   } lssc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_end;    // current word samples the last channel
      logic hit_none;    // scan ending now has no active sensor
      logic div_last;    // last quotient bit this cycle
   } lssc_stat_type;

endpackage

`default_nettype wire

// ===== src/lssc_ifs.sv =====
`default_nettype none

// Sensor level words in
interface lssc_req_if;
   logic valid;
   logic ready;
   logic sensor_level;
   modport source (output valid, output sensor_level, input ready);
   modport sink   (input valid, input sensor_level, output ready);
endinterface

// Scan result words out
interface lssc_rsp_if import lssc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [MUX_W-1:0]        mux_address;
   logic [MAP_W-1:0]        sensor_map;
   logic signed [POS_W-1:0] line_position;
   logic                    position_update;
   logic                    line_lost;
   modport source (output valid, output mux_address, output sensor_map,
                   output line_position, output position_update, output line_lost,
                   input ready);
   modport sink   (input valid, input mux_address, input sensor_map,
                   input line_position, input position_update, input line_lost,
                   output ready);
endinterface

// Settle register write
interface lssc_csr_if import lssc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SETTLE_W-1:0] settle_ticks;
   modport source (output valid, output settle_ticks, input ready);
   modport sink   (input valid, input settle_ticks, output ready);
endinterface

`default_nettype wire

// ===== src/lssc_ctrl.sv =====
`default_nettype none

module lssc_ctrl import lssc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire lssc_stat_type stat,
   output lssc_cmd_type       cmd
);

   lssc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   // Output slot is free when empty or drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.div_start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = rsp_free;
            cmd.step      = req_valid && rsp_free;
            cmd.div_start = req_valid && rsp_free && stat.scan_end && !stat.hit_none;
         end
         ST_DIV: begin
            cmd.div_run = 1'b1;
         end
         ST_FIN: begin
            cmd.div_finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.div_finish || (cmd.step && !cmd.div_start)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/lssc_dp.sv =====
`default_nettype none

module lssc_dp import lssc_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lssc_cmd_type        cmd,
   output lssc_stat_type            stat,
   input  wire logic                req_level,
   input  wire logic                csr_we,
   input  wire logic [SETTLE_W-1:0] csr_settle,
   output logic [MUX_W-1:0]         rsp_mux,
   output logic [MAP_W-1:0]         rsp_map,
   output logic signed [POS_W-1:0]  rsp_pos,
   output logic                     rsp_update,
   output logic                     rsp_lost
);

   localparam int CH_W  = $clog2(NUM_CHANNELS);
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
   // bound on the weight sum: every channel at the largest weight magnitude
   localparam int MAG_W = $clog2(NUM_CHANNELS * 128 * (NUM_CHANNELS - 1) + 1);
   localparam int TOT_W = MAG_W + 1;
   localparam int BIT_W = $clog2(MAG_W);
   localparam logic [CH_W-1:0]         LAST_CH = CH_W'(NUM_CHANNELS - 1);
   localparam logic signed [TOT_W-1:0] W_OFF   = TOT_W'(128 * (NUM_CHANNELS - 1));
   localparam logic [BIT_W-1:0]        LAST_BIT = BIT_W'(MAG_W - 1);

   // Scan state
   logic [SETTLE_W-1:0]     settle_ff;
   logic [SETTLE_W-1:0]     cnt_ff;
   logic [CH_W-1:0]         ch_ff;
   logic [NUM_CHANNELS-1:0] bits_ff;
   logic signed [TOT_W-1:0] tot_ff;
   logic [CNT_W-1:0]        act_ff;
   logic signed [POS_W-1:0] held_ff;
   logic                    lost_ff;

   // Divider state
   logic [MAG_W-1:0]        mag_ff;
   logic [CNT_W-1:0]        rem_ff;
   logic [CNT_W-1:0]        dvs_ff;
   logic                    neg_ff;
   logic [BIT_W-1:0]        bit_ff;

   // Result register
   logic [MUX_W-1:0]        rsp_mux_ff;
   logic [MAP_W-1:0]        rsp_map_ff;
   logic signed [POS_W-1:0] rsp_pos_ff;
   logic                    rsp_update_ff;
   logic                    rsp_lost_ff;

   logic [SETTLE_W-1:0]     limit;
   logic [SETTLE_W-1:0]     cnt_inc;
   logic                    take;
   logic                    hit;
   logic [NUM_CHANNELS-1:0] bits_new;
   logic signed [TOT_W-1:0] weight;
   logic signed [TOT_W-1:0] tot_new;
   logic [CNT_W-1:0]        act_new;
   logic signed [TOT_W-1:0] tot_abs;
   logic [CNT_W:0]          rem_sh;
   logic [CNT_W:0]          rem_sub;
   logic                    q_bit;
   logic signed [TOT_W-1:0] q_s;
   logic signed [TOT_W-1:0] q_res;
   logic signed [POS_W-1:0] pos_res;

   // Settle timer: zero setting acts as one
   assign limit   = (settle_ff == '0) ? SETTLE_W'(1) : settle_ff;
   assign cnt_inc = cnt_ff + SETTLE_W'(1);
   assign take    = (cnt_inc >= limit) || (cnt_inc == '0);
   assign hit     = take && req_level;

   // Map with this word's sample folded in
   always_comb begin
      bits_new        = bits_ff;
      bits_new[ch_ff] = req_level;
   end

   // Running weight sum and hit count over the scan
   assign weight  = $signed({{(TOT_W - CH_W - 8){1'b0}}, ch_ff, 8'b0}) - W_OFF;
   assign tot_new = tot_ff + (hit ? weight : '0);
   assign act_new = act_ff + CNT_W'(hit);
   assign tot_abs = (tot_new < 0) ? -tot_new : tot_new;

   assign stat.scan_end = take && (ch_ff == LAST_CH);
   assign stat.hit_none = (act_new == '0);
   assign stat.div_last = (bit_ff == LAST_BIT);

   // Restoring divide step on magnitude
   assign rem_sh  = {rem_ff, mag_ff[MAG_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign q_bit   = (rem_sh >= {1'b0, dvs_ff});

   // Sign fix, truncation toward zero falls out of the magnitude divide
   assign q_s     = $signed({1'b0, mag_ff});
   assign q_res   = neg_ff ? -q_s : q_s;
   assign pos_res = POS_W'(q_res);

   // Settle register
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
      end else if (csr_we) begin
         settle_ff <= csr_settle;
      end
   end

   // Scan sequencer and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ch_ff   <= '0;
         bits_ff <= '0;
         tot_ff  <= '0;
         act_ff  <= '0;
         held_ff <= '0;
         lost_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            cnt_ff <= take ? '0 : cnt_inc;
            if (take) begin
               bits_ff <= bits_new;
               ch_ff   <= (ch_ff == LAST_CH) ? '0 : ch_ff + CH_W'(1);
            end
            if (stat.scan_end) begin
               tot_ff  <= '0;
               act_ff  <= '0;
               lost_ff <= stat.hit_none;
            end else begin
               tot_ff <= tot_new;
               act_ff <= act_new;
            end
         end
         if (cmd.div_finish) begin
            held_ff <= pos_res;
         end
      end
   end

   // Divider registers
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         mag_ff <= tot_abs[MAG_W-1:0];
         neg_ff <= tot_new < 0;
         dvs_ff <= act_new;
         rem_ff <= '0;
         bit_ff <= '0;
      end else if (cmd.div_run) begin
         mag_ff <= {mag_ff[MAG_W-2:0], q_bit};
         rem_ff <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         bit_ff <= bit_ff + BIT_W'(1);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_mux_ff    <= MUX_W'(ch_ff);
         rsp_map_ff    <= MAP_W'(take ? bits_new : bits_ff);
         rsp_update_ff <= stat.scan_end;
         rsp_pos_ff    <= held_ff;
         rsp_lost_ff   <= stat.scan_end ? stat.hit_none : lost_ff;
      end else if (cmd.div_finish) begin
         rsp_pos_ff  <= pos_res;
         rsp_lost_ff <= 1'b0;
      end
   end

   assign rsp_mux    = rsp_mux_ff;
   assign rsp_map    = rsp_map_ff;
   assign rsp_pos    = rsp_pos_ff;
   assign rsp_update = rsp_update_ff;
   assign rsp_lost   = rsp_lost_ff;

endmodule

`default_nettype wire

// ===== src/line_sensor_scan_centroid_unit.sv =====
// Channel  | Dir | Words
// req_chan | in  | sensor_level, one per tick
// rsp_chan | out | mux_address, sensor_map, line_position, position_update, line_lost
// csr_chan | in  | settle_ticks, always ready
//
// A word that does not end a scan puts its result straight into the output register.
// A word that ends a scan with active sensors loads the restoring divider, which forms
// the MAG_W-bit quotient (MAG_W = 13 for 8 channels) one bit per cycle, then a sign fix.
// Reset (synchronous, active high) clears scan state, position and flags.
// req_chan.ready drops while the result register is full and not being drained,
// and stays low through the divide and sign fix.
`default_nettype none
`include "line_sensor_scan_centroid_unit_defines.svh"

module line_sensor_scan_centroid_unit import lssc_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lssc_req_if.sink    req_chan,
   lssc_rsp_if.source  rsp_chan,
   lssc_csr_if.sink    csr_chan
);

   lssc_cmd_type  cmd;
   lssc_stat_type stat;

   // Register write always taken
   assign csr_chan.ready = 1'b1;

   lssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lssc_dp #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_level  (req_chan.sensor_level),
      .csr_we     (csr_chan.valid),
      .csr_settle (csr_chan.settle_ticks),
      .rsp_mux    (rsp_chan.mux_address),
      .rsp_map    (rsp_chan.sensor_map),
      .rsp_pos    (rsp_chan.line_position),
      .rsp_update (rsp_chan.position_update),
      .rsp_lost   (rsp_chan.line_lost)
   );

   // Checks
   `LSSC_ASSERT_IMP(a_no_take_while_div, cmd.div_run || cmd.div_finish, !req_chan.ready,
                    "word accepted during divide")
   `LSSC_ASSERT_NXT(a_div_then_finish, cmd.div_run && stat.div_last, cmd.div_finish,
                    "divide did not finish")
   `LSSC_ASSERT_IMP(a_lost_matches_map,
                    (NUM_CHANNELS <= 8) && rsp_chan.valid && rsp_chan.position_update,
                    rsp_chan.line_lost == (rsp_chan.sensor_map == '0),
                    "lost flag disagrees with map")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb import lssc_pkg::*;;

   localparam int NCH          = NUM_CHANNELS_DEF;
   localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
   localparam int HOLD_CYCLES  = 300;    // long output stall
   localparam int SETTLE_GAP   = 20;     // idle gap after the last result so the divider can finish

   // One result word as seen on rsp_chan
   typedef struct packed {
      logic [MUX_W-1:0]        mux_address;
      logic [MAP_W-1:0]        sensor_map;
      logic signed [POS_W-1:0] line_position;
      logic                    position_update;
      logic                    line_lost;
   } scan_word_type;

   // Directed stimulus row: either a settle write or one sensor word
   typedef struct {
      logic                is_cfg;
      logic [SETTLE_W-1:0] cfg_val;
      logic                lvl;
      logic                typed;
      scan_word_type       want;
   } dir_row_type;

   logic clock;
   logic reset;

   lssc_req_if req();
   lssc_rsp_if rsp();
   lssc_csr_if csr();

   line_sensor_scan_centroid_unit #(.NUM_CHANNELS(NCH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // Scanner model state
   logic [SETTLE_W-1:0]     cur_settle = SETTLE_RESET;
   logic [MUX_W-1:0]        cur_chan   = '0;
   logic [SETTLE_W-1:0]     wait_count = '0;
   logic [MAP_W-1:0]        level_map  = '0;
   logic signed [POS_W-1:0] held_pos   = '0;
   logic                    line_gone  = 1'b0;

   scan_word_type pending_words[$];
   dir_row_type   dir_rows[$];

   // Typed expectation for the word currently offered
   logic          pin_typed = 1'b0;
   scan_word_type pin_word  = '0;

   int error_count  = 0;
   int words_in     = 0;
   int scans_done   = 0;
   int scans_lost   = 0;
   int src_idle_pct = 0;
   int snk_idle_pct = 0;
   int hold_trigger = 0;

   // Advance the scanner by one tick and return the word it emits
   function automatic scan_word_type scan_step(input logic lvl);
      scan_word_type       w;
      logic [SETTLE_W-1:0] lim;
      int                  total;
      int                  hits;
      int                  i;
      lim = (cur_settle == '0) ? SETTLE_W'(1) : cur_settle;
      w.mux_address = cur_chan;
      w.position_update = 1'b0;
      wait_count = wait_count + 1'b1;
      if (wait_count >= lim || wait_count == '0) begin
         wait_count = '0;
         level_map[cur_chan] = lvl;
         if (cur_chan == MUX_W'(NCH - 1)) begin
            total = 0;
            hits = 0;
            for (i = 0; i < NCH; i++) begin
               if (level_map[i]) begin
                  total += 256 * i - 128 * (NCH - 1);
                  hits++;
               end
            end
            if (hits == 0) begin
               line_gone = 1'b1;
            end else begin
               held_pos = POS_W'(total / hits);
               line_gone = 1'b0;
            end
            w.position_update = 1'b1;
            cur_chan = '0;
         end else begin
            cur_chan = cur_chan + 1'b1;
         end
      end
      w.sensor_map = level_map;
      w.line_position = held_pos;
      w.line_lost = line_gone;
      return w;
   endfunction

   // Scan pattern: empty, full, single hit, pair or random
   function automatic logic [MAP_W-1:0] pick_pattern();
      logic [MAP_W-1:0] p;
      case ($urandom_range(9))
         0: p = '0;
         1: p = '1;
         2: p = MAP_W'(1) << $urandom_range(NCH - 1);
         3: p = (MAP_W'(1) << $urandom_range(NCH - 1)) | (MAP_W'(1) << $urandom_range(NCH - 1));
         default: p = MAP_W'($urandom);
      endcase
      return p;
   endfunction

   function automatic void add_cfg(input logic [SETTLE_W-1:0] v);
      dir_row_type r;
      r = '{1'b1, v, 1'b0, 1'b0, '0};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_plain(input logic lvl);
      dir_row_type r;
      r = '{1'b0, '0, lvl, 1'b0, '0};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_typed(input logic lvl, input int mux, input int map,
                                     input int pos, input logic upd, input logic lost);
      dir_row_type   r;
      scan_word_type w;
      w.mux_address = MUX_W'(mux);
      w.sensor_map = MAP_W'(map);
      w.line_position = POS_W'(pos);
      w.position_update = upd;
      w.line_lost = lost;
      r = '{1'b0, '0, lvl, 1'b1, w};
      dir_rows.push_back(r);
   endfunction

   task automatic compare_word(input scan_word_type got, input scan_word_type want);
      if (got.mux_address !== want.mux_address) begin
         $error("mux_address: expected %0d, got %0d", want.mux_address, got.mux_address);
         error_count++;
      end
      if (got.sensor_map !== want.sensor_map) begin
         $error("sensor_map: expected %h, got %h", want.sensor_map, got.sensor_map);
         error_count++;
      end
      if (got.line_position !== want.line_position) begin
         $error("line_position: expected %0d, got %0d", want.line_position,
                got.line_position);
         error_count++;
      end
      if (got.position_update !== want.position_update) begin
         $error("position_update: expected %b, got %b", want.position_update,
                got.position_update);
         error_count++;
      end
      if (got.line_lost !== want.line_lost) begin
         $error("line_lost: expected %b, got %b", want.line_lost, got.line_lost);
         error_count++;
      end
   endtask

   // Offer one sensor word, with random gaps, and wait for it to be taken
   task automatic send_level(input logic lvl, input logic typed, input scan_word_type want);
      while ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      pin_typed = typed;
      pin_word = want;
      req.valid <= 1'b1;
      req.sensor_level <= lvl;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Drain all results, let the divider settle, then write the settle register
   task automatic idle_then_write(input logic [SETTLE_W-1:0] v);
      req.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
      csr.valid <= 1'b1;
      csr.settle_ticks <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Handshakes are sampled mid-cycle; everything is stable until the next edge
   always @(negedge clock) begin
      scan_word_type w;
      scan_word_type got;
      if (!reset) begin
         if (csr.valid && csr.ready) cur_settle = csr.settle_ticks;
         if (req.valid && req.ready) begin
            w = scan_step(req.sensor_level);
            if (pin_typed) w = pin_word;
            pending_words.push_back(w);
            words_in++;
         end
         if (rsp.valid && rsp.ready) begin
            got.mux_address = rsp.mux_address;
            got.sensor_map = rsp.sensor_map;
            got.line_position = rsp.line_position;
            got.position_update = rsp.position_update;
            got.line_lost = rsp.line_lost;
            if (got.position_update) begin
               scans_done++;
               if (got.line_lost) scans_lost++;
            end
            if (pending_words.size() == 0) begin
               $error("result word with nothing expected");
               error_count++;
            end else begin
               compare_word(got, pending_words.pop_front());
            end
         end
      end
   end

   // Result receiver: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp.ready <= 1'b0;
            hold_left--;
         end else if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   // Watchdog: too long without any handshake
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
             || (csr.valid && csr.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout after %0d idle cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Main sequence
   initial begin
      int                  k;
      int                  ph;
      logic [MAP_W-1:0]    pattern;
      logic [MUX_W-1:0]    last_chan;
      logic                lvl;
      logic [SETTLE_W-1:0] ph_settle[8];
      int                  ph_count[8];

      reset <= 1'b1;
      req.valid <= 1'b0;
      req.sensor_level <= 1'b0;
      csr.valid <= 1'b0;
      csr.settle_ticks <= '0;
      src_idle_pct = 13;
      snk_idle_pct = 75;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settle, then single hits at both ends and an empty scan
      add_typed(1'b1, 0, 'h00, 0, 1'b0, 1'b0);
      add_typed(1'b1, 0, 'h00, 0, 1'b0, 1'b0);
      add_cfg(16'd1);   // settle lowered mid-wait: sample at once
      add_typed(1'b1, 0, 'h01, 0, 1'b0, 1'b0);
      for (k = 1; k < NCH - 1; k++) add_plain(1'b0);
      add_typed(1'b0, NCH - 1, 'h01, -896, 1'b1, 1'b0);
      for (k = 0; k < NCH - 1; k++) add_plain(1'b0);
      add_typed(1'b1, NCH - 1, 'h80, 896, 1'b1, 1'b0);
      add_cfg(16'd0);   // zero settle acts as one
      for (k = 0; k < NCH - 1; k++) add_plain(1'b0);
      add_typed(1'b0, NCH - 1, 'h00, 896, 1'b1, 1'b1);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg)
            idle_then_write(dir_rows[i].cfg_val);
         else
            send_level(dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].want);
      end

      // Random phases over several settle values
      ph_settle = '{16'd1, 16'd0, 16'd2, 16'd3, SETTLE_W'($urandom_range(40, 4)),
                    16'hFFFF, 16'd5, 16'd1};
      ph_count  = '{300, 200, 200, 150, 150, 150, 100, 100};
      pattern = pick_pattern();
      last_chan = MUX_W'(NCH - 1);
      for (ph = 0; ph < 8; ph++) begin
         idle_then_write(ph_settle[ph]);
         if (ph < 3) begin
            src_idle_pct = 13;
            snk_idle_pct = 75;
         end else if (ph < 6) begin
            src_idle_pct = 75;
            snk_idle_pct = 13;
         end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         if (ph == 0) hold_trigger++;
         for (k = 0; k < ph_count[ph]; k++) begin
            if (cur_chan == '0 && last_chan != '0) pattern = pick_pattern();
            last_chan = cur_chan;
            // mostly the pattern bit of the driven channel, some noise
            lvl = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : pattern[cur_chan];
            send_level(lvl, 1'b0, '0);
         end
      end

      req.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);

      $display("Summary: %0d sensor words, %0d scans finished, %0d with no line seen",
               words_in, scans_done, scans_lost);
      $display("Settle 160, 0, 1..40 and 65535, with a long output stall and three idle mixes");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
